// ===== rtl/core/hcmm_pkg.sv =====
// shared types, constants and tables of the handheld console memory map
package hcmm_pkg;

   localparam int VRAM_BYTES     = 8192;
   localparam int WRAM_BYTES     = 8192;
   localparam int EXT_RAM_BYTES  = 32768;
   localparam int EXT_BANK_BYTES = 8192;
   localparam int OAM_BYTES      = 160;
   localparam int IO_BYTES       = 128;
   localparam int HRAM_BYTES     = 127;

   localparam int VRAM_AW = $clog2(VRAM_BYTES);
   localparam int WRAM_AW = $clog2(WRAM_BYTES);
   localparam int EXT_AW  = $clog2(EXT_RAM_BYTES);
   localparam int BANK_AW = $clog2(EXT_BANK_BYTES);
   localparam int OAM_AW  = $clog2(OAM_BYTES);
   localparam int IO_AW   = $clog2(IO_BYTES);
   localparam int HRAM_AW = $clog2(HRAM_BYTES);

   localparam logic [15:0] DIV_ADDRESS = 16'hFF04;
   localparam logic [7:0]  UNMAPPED    = 8'hFF;

   // access regions
   localparam logic [3:0] RGN_CART = 4'd0;
   localparam logic [3:0] RGN_VRAM = 4'd1;
   localparam logic [3:0] RGN_EXT  = 4'd2;
   localparam logic [3:0] RGN_WRAM = 4'd3;
   localparam logic [3:0] RGN_OAM  = 4'd4;
   localparam logic [3:0] RGN_IO   = 4'd5;
   localparam logic [3:0] RGN_HRAM = 4'd6;
   localparam logic [3:0] RGN_IE   = 4'd7;
   localparam logic [3:0] RGN_NONE = 4'd8;

   typedef struct packed {
      logic              wr;
      logic [3:0]        rgn;
      logic [EXT_AW-1:0] idx;
      logic [7:0]        data;
      logic              divr;
   } dec_type;

   function automatic logic [7:0] io_default(input logic [IO_AW-1:0] idx);
      logic [7:0] val;
      unique case (idx)
         7'h00: val = 8'hCF;
         7'h07: val = 8'hF8;
         7'h0F: val = 8'hE1;
         7'h10: val = 8'h80;
         7'h11: val = 8'hBF;
         7'h12: val = 8'hF3;
         7'h14: val = 8'hBF;
         7'h16: val = 8'h3F;
         7'h19: val = 8'hBF;
         7'h1A: val = 8'h7F;
         7'h1B: val = 8'hFF;
         7'h1C: val = 8'h9F;
         7'h1E: val = 8'hBF;
         7'h20: val = 8'hFF;
         7'h23: val = 8'hBF;
         7'h24: val = 8'h77;
         7'h25: val = 8'hF3;
         7'h26: val = 8'hF1;
         7'h40: val = 8'h91;
         7'h41: val = 8'h81;
         7'h47: val = 8'hFC;
         7'h48: val = 8'hFF;
         7'h49: val = 8'hFF;
         7'h4D: val = 8'hFF;
         7'h4F: val = 8'hFF;
         7'h70: val = 8'hFF;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/hcmm_if.sv =====
// request and response channel interfaces of the memory map
interface hcmm_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic        ext_ram_enable;
   logic [1:0]  ext_ram_bank;

   modport source (output valid, kind, address, write_data, ext_ram_enable, ext_ram_bank,
                   input ready);
   modport sink   (input valid, kind, address, write_data, ext_ram_enable, ext_ram_bank,
                   output ready);
endinterface

interface hcmm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       to_cartridge;
   logic       divider_reset;

   modport source (output valid, read_data, to_cartridge, divider_reset, input ready);
   modport sink   (input valid, read_data, to_cartridge, divider_reset, output ready);
endinterface

// ===== rtl/core/hcmm_decode.sv =====
// address decoder: region, store index and write data of one access
module hcmm_decode
   import hcmm_pkg::*;
(
   input  logic        kind,
   input  logic [15:0] address,
   input  logic [7:0]  write_data,
   input  logic        ext_ram_enable,
   input  logic [1:0]  ext_ram_bank,
   input  logic [15:0] ext_ram_size,
   output dec_type     dec
);

   logic [EXT_AW-1:0] ext_off;
   logic              ext_hit;

   always_comb begin
      ext_off = EXT_AW'(address[BANK_AW-1:0]);
      if (ext_ram_size > 16'(EXT_BANK_BYTES)) begin
         ext_off = ext_off + EXT_AW'({ext_ram_bank, {BANK_AW{1'b0}}});
      end
      ext_hit = ext_ram_enable && (ext_ram_size != 16'd0) && (17'(ext_off) < 17'(ext_ram_size));
   end

   always_comb begin
      dec.wr   = kind;
      dec.data = write_data;
      dec.divr = 1'b0;
      dec.rgn  = RGN_NONE;
      dec.idx  = '0;
      priority if (address <= 16'h7FFF) begin
         dec.rgn = RGN_CART;
      end else if (address <= 16'h9FFF) begin
         dec.rgn = RGN_VRAM;
         dec.idx = EXT_AW'(address[VRAM_AW-1:0]);
      end else if (address <= 16'hBFFF) begin
         dec.rgn = ext_hit ? RGN_EXT : RGN_NONE;
         dec.idx = ext_off;
      end else if (address <= 16'hFDFF) begin
         // work ram and its echo share the low bits
         dec.rgn = RGN_WRAM;
         dec.idx = EXT_AW'(address[WRAM_AW-1:0]);
      end else if (address <= 16'hFE9F) begin
         dec.rgn = RGN_OAM;
         dec.idx = EXT_AW'(address[OAM_AW-1:0]);
      end else if (address <= 16'hFEFF) begin
         dec.rgn = RGN_NONE;
      end else if (address <= 16'hFF7F) begin
         dec.rgn = RGN_IO;
         dec.idx = EXT_AW'(address[IO_AW-1:0]);
         if (kind && (address == DIV_ADDRESS)) begin
            dec.divr = 1'b1;
            dec.data = 8'h00;
         end
      end else if (address <= 16'hFFFE) begin
         dec.rgn = RGN_HRAM;
         dec.idx = EXT_AW'(address[HRAM_AW-1:0]);
      end else begin
         dec.rgn = RGN_IE;
      end
   end

endmodule

// ===== rtl/core/hcmm_store.sv =====
// internal stores with registered reads and the power-up clearing sweep
module hcmm_store
   import hcmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  dec_type    dec,
   output logic       busy,
   output logic [7:0] read_data
);

   logic [7:0] vram [0:VRAM_BYTES-1];
   logic [7:0] wram [0:WRAM_BYTES-1];
   logic [7:0] eram [0:EXT_RAM_BYTES-1];
   logic [7:0] oam  [0:OAM_BYTES-1];
   logic [7:0] io   [0:IO_BYTES-1];
   logic [7:0] hram [0:HRAM_BYTES-1];

   logic [EXT_AW-1:0] clr_ff, clr_in;
   logic              busy_ff, busy_in;
   logic [7:0]        ie_ff, ie_in;
   logic [3:0]        rgn_ff;
   logic              wr_ff;
   logic [7:0]        vram_q_ff, wram_q_ff, eram_q_ff, oam_q_ff, io_q_ff, hram_q_ff;

   logic acc_wr, acc_rd;
   logic vram_we, wram_we, eram_we, oam_we, io_we, hram_we;
   logic [VRAM_AW-1:0] vram_wa;
   logic [WRAM_AW-1:0] wram_wa;
   logic [EXT_AW-1:0]  eram_wa;
   logic [OAM_AW-1:0]  oam_wa;
   logic [IO_AW-1:0]   io_wa;
   logic [HRAM_AW-1:0] hram_wa;
   logic [7:0]         wd, io_wd;

   assign acc_wr = fire && dec.wr;
   assign acc_rd = fire && !dec.wr;
   assign busy   = busy_ff;

   // clearing sweep
   always_comb begin
      clr_in  = clr_ff + 1'b1;
      busy_in = busy_ff && (clr_ff != {EXT_AW{1'b1}});
      ie_in   = ie_ff;
      if (acc_wr && (dec.rgn == RGN_IE)) begin
         ie_in = dec.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
         ie_ff   <= 8'h00;
      end else begin
         clr_ff  <= busy_ff ? clr_in : clr_ff;
         busy_ff <= busy_in;
         ie_ff   <= ie_in;
      end
   end

   // write ports
   always_comb begin
      wd      = busy_ff ? 8'h00 : dec.data;
      io_wd   = busy_ff ? io_default(clr_ff[IO_AW-1:0]) : dec.data;
      vram_wa = busy_ff ? clr_ff[VRAM_AW-1:0] : dec.idx[VRAM_AW-1:0];
      wram_wa = busy_ff ? clr_ff[WRAM_AW-1:0] : dec.idx[WRAM_AW-1:0];
      eram_wa = busy_ff ? clr_ff : dec.idx;
      oam_wa  = busy_ff ? clr_ff[OAM_AW-1:0] : dec.idx[OAM_AW-1:0];
      io_wa   = busy_ff ? clr_ff[IO_AW-1:0] : dec.idx[IO_AW-1:0];
      hram_wa = busy_ff ? clr_ff[HRAM_AW-1:0] : dec.idx[HRAM_AW-1:0];
      vram_we = busy_ff || (acc_wr && (dec.rgn == RGN_VRAM));
      wram_we = busy_ff || (acc_wr && (dec.rgn == RGN_WRAM));
      eram_we = busy_ff || (acc_wr && (dec.rgn == RGN_EXT));
      oam_we  = (busy_ff && (clr_ff < EXT_AW'(OAM_BYTES))) || (acc_wr && (dec.rgn == RGN_OAM));
      io_we   = (busy_ff && (clr_ff < EXT_AW'(IO_BYTES))) || (acc_wr && (dec.rgn == RGN_IO));
      hram_we = (busy_ff && (clr_ff < EXT_AW'(HRAM_BYTES)))
                || (acc_wr && (dec.rgn == RGN_HRAM));
   end

   always_ff @(posedge clock) begin
      if (vram_we) begin
         vram[vram_wa] <= wd;
      end
      if (acc_rd) begin
         vram_q_ff <= vram[dec.idx[VRAM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wram_we) begin
         wram[wram_wa] <= wd;
      end
      if (acc_rd) begin
         wram_q_ff <= wram[dec.idx[WRAM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (eram_we) begin
         eram[eram_wa] <= wd;
      end
      if (acc_rd) begin
         eram_q_ff <= eram[dec.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (oam_we) begin
         oam[oam_wa] <= wd;
      end
      if (acc_rd && (dec.rgn == RGN_OAM)) begin
         oam_q_ff <= oam[dec.idx[OAM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (io_we) begin
         io[io_wa] <= io_wd;
      end
      if (acc_rd) begin
         io_q_ff <= io[dec.idx[IO_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (hram_we) begin
         hram[hram_wa] <= wd;
      end
      if (acc_rd && (dec.rgn == RGN_HRAM)) begin
         hram_q_ff <= hram[dec.idx[HRAM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rgn_ff <= dec.rgn;
         wr_ff  <= dec.wr;
      end
   end

   // result byte
   always_comb begin
      unique case (rgn_ff)
         RGN_VRAM: read_data = vram_q_ff;
         RGN_EXT:  read_data = eram_q_ff;
         RGN_WRAM: read_data = wram_q_ff;
         RGN_OAM:  read_data = oam_q_ff;
         RGN_IO:   read_data = io_q_ff;
         RGN_HRAM: read_data = hram_q_ff;
         RGN_IE:   read_data = ie_ff;
         default:  read_data = UNMAPPED;
      endcase
      if (wr_ff) begin
         read_data = 8'h00;
      end
   end

endmodule

// ===== rtl/core/handheld_console_memory_map.sv =====
// top level of the handheld console memory map
//
//   channel  direction  contents
//   req      in         kind, address, write_data, ext_ram_enable, ext_ram_bank
//   rsp      out        read_data, to_cartridge, divider_reset
//   csr      in         ext_ram_size write
//
// one word per cycle while rsp is ready and no sweep runs; a word is held
// in the input register and leaves from the result register.
// after reset a clearing sweep writes every store, one address a cycle
// over the 32768-byte external ram, and req is not ready until it ends.
// a stalled rsp holds the result and the input register takes one more word.
module handheld_console_memory_map
   import hcmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   hcmm_req_if.sink          req_chan,
   hcmm_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [15:0]       csr_write_data
);

   logic        s1_vld_ff, s1_vld_in;
   logic        s2_vld_ff, s2_vld_in;
   logic        kind_ff;
   logic [15:0] address_ff;
   logic [7:0]  write_data_ff;
   logic        ext_ram_enable_ff;
   logic [1:0]  ext_ram_bank_ff;
   logic [15:0] ext_ram_size_ff;
   logic        cart_ff, divr_ff;
   logic        fire, take, busy;
   logic [7:0]  read_data;
   dec_type     dec;

   assign fire           = s1_vld_ff && (!s2_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !busy && (!s1_vld_ff || fire);
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_vld_in = take || (s1_vld_ff && !fire);
      s2_vld_in = fire || (s2_vld_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
         ext_ram_size_ff <= 16'd0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         if (csr_write_enable) begin
            ext_ram_size_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff           <= req_chan.kind;
         address_ff        <= req_chan.address;
         write_data_ff     <= req_chan.write_data;
         ext_ram_enable_ff <= req_chan.ext_ram_enable;
         ext_ram_bank_ff   <= req_chan.ext_ram_bank;
      end
      if (fire) begin
         cart_ff <= (dec.rgn == RGN_CART);
         divr_ff <= dec.divr;
      end
   end

   hcmm_decode u_decode (
      .kind           (kind_ff),
      .address        (address_ff),
      .write_data     (write_data_ff),
      .ext_ram_enable (ext_ram_enable_ff),
      .ext_ram_bank   (ext_ram_bank_ff),
      .ext_ram_size   (ext_ram_size_ff),
      .dec            (dec)
   );

   hcmm_store u_store (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .dec       (dec),
      .busy      (busy),
      .read_data (read_data)
   );

   assign rsp_chan.valid         = s2_vld_ff;
   assign rsp_chan.read_data     = read_data;
   assign rsp_chan.to_cartridge  = cart_ff;
   assign rsp_chan.divider_reset = divr_ff;

endmodule
